>>> rtl/core/gcbw_pkg.sv
// gcbw_pkg: shared constants and types for the graph cut boundary weight core
// depends on nothing; imported by every gcbw module and the top level

package gcbw_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MEM_DEPTH  = 4 * MAX_WIDTH;
  localparam int ADDR_W     = $clog2(MEM_DEPTH);
  localparam int DIM_W      = 11;
  localparam int CNT_W      = 21;
  localparam int PIX_W      = 24;
  localparam int WGT_W      = 16;
  localparam int SUM_W      = 19;
  localparam int SCALE_W    = 24;
  localparam int NB_NUM     = 8;

  localparam logic [DIM_W-1:0]   WIDTH_RESET  = 11'd640;
  localparam logic [DIM_W-1:0]   HEIGHT_RESET = 11'd480;
  localparam logic [SCALE_W-1:0] SCALE_RESET  = 24'd3025544;
  localparam logic [23:0]        INV_SQRT2    = 24'd11863283;
  localparam logic [19:0]        K_ONE        = 20'd65536;
  localparam logic [19:0]        K_SAT        = 20'd524287;

  // register indexes on the config port
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_SCALE  = 2'd2;

  // item kinds on the input stream
  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  // control that travels with each pixel pair through the weight unit
  typedef struct packed {
    logic       valid;
    logic       in_img;
    logic       diag;
    logic [2:0] idx;
  } wu_tag_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } seq_state_t;

endpackage

>>> rtl/core/gcbw_pixel_mem.sv
// gcbw_pixel_mem: pixel store, one write port and one registered read port
// depends on gcbw_pkg

module gcbw_pixel_mem
  import gcbw_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [PIX_W-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [PIX_W-1:0]  rd_data
);

  logic [PIX_W-1:0] mem [MEM_DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/core/gcbw_weight_unit.sv
// gcbw_weight_unit: shared four stage unit, color distance to boundary weight
// depends on gcbw_pkg

module gcbw_weight_unit
  import gcbw_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  wu_tag_t            in_tag,
  input  logic [PIX_W-1:0]   center,
  input  logic [PIX_W-1:0]   nbr,
  input  logic [SCALE_W-1:0] scale,
  output wu_tag_t            out_tag,
  output logic [WGT_W-1:0]   weight
);

  wu_tag_t      a_tag, b_tag, c_tag;
  logic [17:0]  a_d2;
  logic [41:0]  b_t;
  logic [24:0]  c_q;

  logic [7:0]   dr, dg, db;
  logic [17:0]  d2;
  logic [17:0]  n_int;
  logic [24:0]  q_lin;
  logic [48:0]  q_prod;
  logic [24:0]  q_fin;

  // stage a: squared color distance
  always_comb begin
    dr = (center[7:0] > nbr[7:0]) ? center[7:0] - nbr[7:0] : nbr[7:0] - center[7:0];
    dg = (center[15:8] > nbr[15:8]) ? center[15:8] - nbr[15:8] : nbr[15:8] - center[15:8];
    db = (center[23:16] > nbr[23:16]) ? center[23:16] - nbr[23:16]
                                      : nbr[23:16] - center[23:16];
    d2 = 18'(dr * dr) + 18'(dg * dg) + 18'(db * db);
  end

  // stage c: base two exponential, linear in the fraction
  always_comb begin
    n_int = b_t[41:24];
    if (n_int >= 18'd25) begin
      q_lin = '0;
    end else begin
      q_lin = (25'h100_0000 - 25'(b_t[23:1])) >> n_int[4:0];
    end
  end

  // stage d: diagonal scaling, cut to q0.16 and saturate
  always_comb begin
    q_prod = c_q * INV_SQRT2;
    q_fin  = c_tag.diag ? q_prod[48:24] : c_q;
  end

  // pipeline registers
  always_ff @(posedge clk) begin
    if (rst) begin
      a_tag   <= '0;
      b_tag   <= '0;
      c_tag   <= '0;
      out_tag <= '0;
    end else begin
      a_tag   <= in_tag;
      b_tag   <= a_tag;
      c_tag   <= b_tag;
      out_tag <= c_tag;
    end
    a_d2 <= d2;
    b_t  <= a_d2 * scale;
    c_q  <= q_lin;
    if (!c_tag.in_img) begin
      weight <= '0;
    end else if (q_fin[24]) begin
      weight <= '1;
    end else begin
      weight <= q_fin[23:8];
    end
  end

endmodule

>>> rtl/core/graph_cut_boundary_weights_core.sv
// graph_cut_boundary_weights_core: eight neighbor boundary weights per pixel
// depends on gcbw_pkg, gcbw_pixel_mem, gcbw_weight_unit
//
// channel  dir  handshake               payload
// s_*      in   s_tvalid / s_tready     tdata rgb, tuser pixel or flush
// m_*      out  m_tvalid / m_tready     tdata index, weights, mask, bound; tlast
// apb      in   psel, penable, pready   width, height, exp scale
//
// an item that emits a center holds the input off after its accept, through
// 9 store reads, the registered store read, 4 weight unit stages and a
// closing state; other items do not hold the input off
// reset clears counts and config to defaults; store contents stay undefined
// the result waits in the output register while the next item is taken;
// a finished center waits for that register to free up

module graph_cut_boundary_weights_core
  import gcbw_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [23:0]  s_tdata,   // red, green, blue
  input  logic         s_tuser,   // action
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [175:0] m_tdata,   // center_index, weights ul u ur l r dl d dr,
                                  // neighbor_mask, penalty_bound, zero pad
  output logic         m_tlast,   // frame_done
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  seq_state_t state;
  logic [DIM_W-1:0]   image_width, image_height;
  logic [SCALE_W-1:0] exp_scale;
  logic [DIM_W-1:0]   eff_w, eff_h;
  logic [CNT_W-1:0]   total;
  logic [CNT_W-1:0]   arrived, emitted;
  logic [DIM_W-1:0]   e_row, e_col;
  logic [SUM_W-1:0]   max_sum, wsum;
  logic [3:0]         slot;
  logic               rd_vld;
  logic [3:0]         rd_slot;
  logic [PIX_W-1:0]   center, rd_data;
  logic [ADDR_W-1:0]  rd_addr;
  logic [WGT_W-1:0]   weights [NB_NUM];
  logic [NB_NUM-1:0]  mask;
  wu_tag_t            wu_in, wu_out;
  logic [WGT_W-1:0]   wu_weight;
  logic               cfg_wr, restart, accept, pix_ok, emit, out_free, last_c;
  logic [SUM_W-1:0]   max_next;
  logic [19:0]        kb;
  logic [ADDR_W-1:0]  e_lo, w_lo;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
      exp_scale    <= SCALE_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_WIDTH:  image_width  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: image_height <= pwdata[DIM_W-1:0];
        REG_SCALE:  exp_scale    <= pwdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (paddr[3:2])
      REG_WIDTH:  prdata = 32'(image_width);
      REG_HEIGHT: prdata = 32'(image_height);
      REG_SCALE:  prdata = 32'(exp_scale);
      default:    prdata = '0;
    endcase
  end

  // effective frame size
  always_comb begin
    if (image_width == '0) begin
      eff_w = DIM_W'(1);
    end else if (image_width > DIM_W'(MAX_WIDTH)) begin
      eff_w = DIM_W'(MAX_WIDTH);
    end else begin
      eff_w = image_width;
    end
    eff_h = (image_height == '0) ? DIM_W'(1) : image_height;
    total = CNT_W'(22'(eff_w) * 22'(eff_h));
  end

  // accept decision
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid & s_tready;
  assign pix_ok   = (s_tuser == ACT_PIXEL) && (arrived < total);
  always_comb begin
    if (s_tuser == ACT_PIXEL) begin
      emit = pix_ok && ((CNT_W+1)'(arrived) > (CNT_W+1)'(emitted) + (CNT_W+1)'(eff_w))
             && (emitted < total);
    end else begin
      emit = (arrived >= total) && (emitted < total);
    end
  end

  // neighbor inside flags, order ul u ur l r dl d dr
  always_comb begin
    logic up_ok, dn_ok, lf_ok, rt_ok;
    up_ok = (e_row != '0);
    dn_ok = (e_row + DIM_W'(1)) < eff_h;
    lf_ok = (e_col != '0);
    rt_ok = (e_col + DIM_W'(1)) < eff_w;
    mask  = {dn_ok & rt_ok, dn_ok, dn_ok & lf_ok, rt_ok, lf_ok,
             up_ok & rt_ok, up_ok, up_ok & lf_ok};
  end

  // store read address for each slot: center then the eight neighbors
  assign e_lo = emitted[ADDR_W-1:0];
  assign w_lo = ADDR_W'(eff_w);
  always_comb begin
    case (slot)
      4'd1:    rd_addr = e_lo - w_lo - ADDR_W'(1);
      4'd2:    rd_addr = e_lo - w_lo;
      4'd3:    rd_addr = e_lo - w_lo + ADDR_W'(1);
      4'd4:    rd_addr = e_lo - ADDR_W'(1);
      4'd5:    rd_addr = e_lo + ADDR_W'(1);
      4'd6:    rd_addr = e_lo + w_lo - ADDR_W'(1);
      4'd7:    rd_addr = e_lo + w_lo;
      4'd8:    rd_addr = e_lo + w_lo + ADDR_W'(1);
      default: rd_addr = e_lo;
    endcase
  end

  gcbw_pixel_mem u_mem (
    .clk     (clk),
    .wr_en   (accept & pix_ok),
    .wr_addr (arrived[ADDR_W-1:0]),
    .wr_data (s_tdata),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // tag for the pixel pair entering the weight unit
  always_comb begin
    logic [2:0] k;
    k            = 3'(rd_slot - 4'd1);
    wu_in.valid  = rd_vld && (rd_slot != 4'd0);
    wu_in.idx    = k;
    wu_in.in_img = mask[k];
    wu_in.diag   = (k == 3'd0) || (k == 3'd2) || (k == 3'd5) || (k == 3'd7);
  end

  gcbw_weight_unit u_wu (
    .clk     (clk),
    .rst     (rst),
    .in_tag  (wu_in),
    .center  (center),
    .nbr     (rd_data),
    .scale   (exp_scale),
    .out_tag (wu_out),
    .weight  (wu_weight)
  );

  // closing values
  assign out_free = !m_tvalid || m_tready;
  assign max_next = (wsum > max_sum) ? wsum : max_sum;
  assign last_c   = (emitted + CNT_W'(1)) >= total;
  assign kb       = (K_ONE + 20'(max_next) > K_SAT) ? K_SAT : K_ONE + 20'(max_next);
  assign restart  = cfg_wr && ((paddr[3:2] == REG_WIDTH) || (paddr[3:2] == REG_HEIGHT));

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      slot    <= '0;
      rd_vld  <= 1'b0;
      rd_slot <= '0;
      arrived <= '0;
      emitted <= '0;
      max_sum <= '0;
      e_row   <= '0;
      e_col   <= '0;
    end else begin
      rd_vld  <= (state == ST_ISSUE);
      rd_slot <= slot;
      unique case (state)
        ST_IDLE: begin
          if (restart) begin
            arrived <= '0;
            emitted <= '0;
            max_sum <= '0;
            e_row   <= '0;
            e_col   <= '0;
          end else if (accept) begin
            if (pix_ok) begin
              arrived <= arrived + CNT_W'(1);
            end
            if (emit) begin
              slot  <= '0;
              state <= ST_ISSUE;
            end
          end
        end
        ST_ISSUE: begin
          slot <= slot + 4'd1;
          if (slot == 4'd8) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (wu_out.valid && (wu_out.idx == 3'd7)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
            if (last_c) begin
              arrived <= '0;
              emitted <= '0;
              max_sum <= '0;
              e_row   <= '0;
              e_col   <= '0;
            end else begin
              emitted <= emitted + CNT_W'(1);
              max_sum <= max_next;
              if (e_col + DIM_W'(1) == eff_w) begin
                e_col <= '0;
                e_row <= e_row + DIM_W'(1);
              end else begin
                e_col <= e_col + DIM_W'(1);
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // center capture and weight collection
  always_ff @(posedge clk) begin
    if (rd_vld && (rd_slot == 4'd0)) begin
      center <= rd_data;
    end
    if (state == ST_IDLE) begin
      wsum <= '0;
    end else if (wu_out.valid) begin
      weights[wu_out.idx] <= wu_weight;
      wsum <= wsum + SUM_W'(wu_weight);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == ST_DONE) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      m_tdata <= {1'b0, last_c ? kb[SUM_W-1:0] : {SUM_W{1'b0}}, mask,
                  weights[7], weights[6], weights[5], weights[4],
                  weights[3], weights[2], weights[1], weights[0], emitted[19:0]};
      m_tlast <= last_c;
    end
  end

endmodule

>>> rtl/core/gcbw_checker.sv
// gcbw_checker: port level checks on the boundary weight core
// depends on gcbw_pkg for the shared import; bound to the top level below

module gcbw_checker
  import gcbw_pkg::*;
(
  input logic         clk,
  input logic         rst,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [175:0] m_tdata,
  input logic         m_tlast,
  input logic         pready
);

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // a new result only follows a busy interval
  a_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result without a busy interval");

  // frame end carries a bound of at least one
  a_kmin: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> (m_tdata[174:172] != 3'd0))
    else $error("frame bound below one");

  // other results carry no bound
  a_kzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> (m_tdata[174:156] == 19'd0))
    else $error("bound on a non final result");

  // config port never stalls
  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("config port stalled");

endmodule

bind graph_cut_boundary_weights_core gcbw_checker u_gcbw_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .pready   (pready)
);

>>> bench/tb_graph_cut_boundary_weights_core.sv
// tb_graph_cut_boundary_weights_core: self-checking bench for the boundary weight core
// depends on gcbw_pkg and graph_cut_boundary_weights_core; predicts every result internally
`timescale 1ns / 100ps

module tb_graph_cut_boundary_weights_core;
  import gcbw_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 60;

  typedef struct packed {
    logic        act;
    logic [23:0] rgb;
  } pixel_req_t;

  typedef struct packed {
    logic [19:0]      idx;
    logic [7:0][15:0] wt;
    logic [7:0]       mask;
    logic [18:0]      bound;
    logic             done;
  } center_res_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [23:0]  s_tdata = '0;
  logic         s_tuser = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [175:0] m_tdata;
  logic         m_tlast;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [3:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  graph_cut_boundary_weights_core u_dut (.*);

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  pixel_req_t  pending_reqs[$];
  center_res_t expected_centers[$];
  int          err_count = 0;
  int          idle_phase = 0;      // 0 none, 1 sender, 2 receiver, 3 both
  int          hold_req = 0;        // bumped to ask for a long receiver hold
  int          hold_seen = 0;
  int          hold_left = 0;
  bit          s_took = 1'b0;
  int          quiet_cycles = 0;
  string       wt_names[8] = '{"weight_up_left", "weight_up", "weight_up_right",
                               "weight_left", "weight_right", "weight_down_left",
                               "weight_down", "weight_down_right"};

  // shadow of the block: config and frame progress
  logic [10:0] cfg_width  = WIDTH_RESET;
  logic [10:0] cfg_height = HEIGHT_RESET;
  logic [23:0] cfg_scale  = SCALE_RESET;
  logic [23:0] frame_pix[int unsigned];
  int unsigned arrived = 0;
  int unsigned emitted = 0;
  int unsigned max_sum = 0;

  function automatic logic [15:0] boundary_weight(logic [23:0] a, logic [23:0] b, bit diag);
    logic [31:0] d2;
    logic [31:0] dd;
    logic [63:0] t;
    logic [63:0] q;
    d2 = 0;
    for (int ch = 0; ch < 3; ch++) begin
      dd = 32'((a[8*ch+:8] > b[8*ch+:8]) ? a[8*ch+:8] - b[8*ch+:8] : b[8*ch+:8] - a[8*ch+:8]);
      d2 += dd * dd;
    end
    t = {32'd0, d2} * {40'd0, cfg_scale};
    if (t[63:24] >= 25) q = 0;
    else q = (64'd16777216 - {41'd0, t[23:1]}) >> t[28:24];
    if (diag) q = (q * 64'd11863283) >> 24;
    q = q >> 8;
    if (q > 65535) q = 65535;
    return q[15:0];
  endfunction

  // works out the result (if any) caused by one accepted request
  task automatic predict_center(pixel_req_t r);
    int unsigned w, h, total, e, j;
    int          row, col, nr, nc;
    int          dr[8] = '{-1, -1, -1, 0, 0, 1, 1, 1};
    int          dc[8] = '{-1, 0, 1, -1, 1, -1, 0, 1};
    int unsigned sum, kb;
    center_res_t res;
    w = (cfg_width == 0) ? 1 : (cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width;
    h = (cfg_height == 0) ? 1 : cfg_height;
    total = w * h;
    if (r.act == ACT_PIXEL) begin
      if (arrived >= total) return;
      frame_pix[arrived] = r.rgb;
      arrived++;
      if (!(arrived > emitted + w + 1 && emitted < total)) return;
    end else begin
      if (arrived < total || emitted >= total) return;
    end
    e = emitted;
    row = e / w;
    col = e % w;
    res = '0;
    res.idx = e[19:0];
    sum = 0;
    for (int k = 0; k < 8; k++) begin
      nr = row + dr[k];
      nc = col + dc[k];
      if (nr >= 0 && nr < int'(h) && nc >= 0 && nc < int'(w)) begin
        j = nr * w + nc;
        res.wt[k] = boundary_weight(frame_pix[e], frame_pix[j], dr[k] != 0 && dc[k] != 0);
        res.mask[k] = 1'b1;
      end
      sum += res.wt[k];
    end
    if (sum > max_sum) max_sum = sum;
    emitted = e + 1;
    if (emitted >= total) begin
      kb = 65536 + max_sum;
      res.bound = (kb > 524287) ? 19'd524287 : kb[18:0];
      res.done = 1'b1;
      arrived = 0;
      emitted = 0;
      max_sum = 0;
      frame_pix.delete();
    end
    expected_centers.push_back(res);
  endtask

  // request acceptance, result check and watchdog, all at the rising edge
  always @(posedge clk) begin
    center_res_t got;
    center_res_t exp_res;
    s_took = 1'b0;
    if (!rst && s_tvalid && s_tready) begin
      s_took = 1'b1;
      predict_center(pending_reqs.pop_front());
    end
    if (!rst && m_tvalid && m_tready) begin
      got.idx   = m_tdata[19:0];
      for (int k = 0; k < 8; k++) got.wt[k] = m_tdata[20+16*k +: 16];
      got.mask  = m_tdata[155:148];
      got.bound = m_tdata[174:156];
      got.done  = m_tlast;
      if (expected_centers.size() == 0) begin
        $error("unexpected result for center %0d", got.idx);
        err_count++;
      end else begin
        exp_res = expected_centers.pop_front();
        if (got.idx !== exp_res.idx) begin
          $error("center_index exp %0d got %0d", exp_res.idx, got.idx);
          err_count++;
        end
        for (int k = 0; k < 8; k++)
          if (got.wt[k] !== exp_res.wt[k]) begin
            $error("%s exp %0d got %0d", wt_names[k], exp_res.wt[k], got.wt[k]);
            err_count++;
          end
        if (got.mask !== exp_res.mask) begin
          $error("neighbor_mask exp %h got %h", exp_res.mask, got.mask);
          err_count++;
        end
        if (got.bound !== exp_res.bound) begin
          $error("penalty_bound exp %0d got %0d", exp_res.bound, got.bound);
          err_count++;
        end
        if (got.done !== exp_res.done) begin
          $error("frame_done exp %0d got %0d", exp_res.done, got.done);
          err_count++;
        end
      end
    end
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // request driver, inputs move on the falling edge
  always @(negedge clk) begin
    bit gap;
    gap = (idle_phase == 1) ? ($urandom_range(99) < 75) :
          (idle_phase == 3) ? ($urandom_range(99) < 18) : 1'b0;
    if (!rst && (!s_tvalid || s_took)) begin
      if (pending_reqs.size() > 0 && !gap) begin
        s_tvalid <= 1'b1;
        s_tuser  <= pending_reqs[0].act;
        s_tdata  <= pending_reqs[0].rgb;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result receiver with random stalls and a long hold on request
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (idle_phase == 2) begin
      m_tready <= ($urandom_range(99) >= 75);
    end else if (idle_phase == 3) begin
      m_tready <= ($urandom_range(99) >= 18);
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || expected_centers.size() > 0 || s_tvalid)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // config write at idle: setup then access cycle
  task automatic reg_write(logic [1:0] index, logic [31:0] value);
    wait_drained();
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (index)
      REG_WIDTH: begin
        cfg_width = value[10:0];
        arrived = 0; emitted = 0; max_sum = 0; frame_pix.delete();
      end
      REG_HEIGHT: begin
        cfg_height = value[10:0];
        arrived = 0; emitted = 0; max_sum = 0; frame_pix.delete();
      end
      REG_SCALE: cfg_scale = value[23:0];
      default: ;
    endcase
  endtask

  function automatic void add_req(logic act, logic [23:0] rgb);
    pixel_req_t r;
    r.act = act;
    r.rgb = rgb;
    pending_reqs.push_back(r);
  endfunction

  // pixel near a base color so weights are mostly nonzero
  function automatic logic [23:0] near_color(logic [23:0] base);
    logic [23:0] p;
    if ($urandom_range(9) == 0) return 24'($urandom());
    for (int ch = 0; ch < 3; ch++)
      p[8*ch+:8] = 8'(base[8*ch+:8] + $urandom_range(6) - 3);
    return p;
  endfunction

  // one whole frame of pixels, trailing flushes and a little noise
  task automatic queue_frame(int w, int h);
    logic [23:0] base;
    base = 24'($urandom());
    for (int i = 0; i < w * h; i++) begin
      if ($urandom_range(40) == 0) add_req(ACT_FLUSH, 24'($urandom()));
      add_req(ACT_PIXEL, near_color(base));
    end
    if ($urandom_range(3) == 0) add_req(ACT_PIXEL, 24'($urandom()));
    for (int i = 0; i < w + 2 + $urandom_range(2); i++) add_req(ACT_FLUSH, 24'($urandom()));
  endtask

  int phase_count;

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: small frame with extreme colors, early flush, late pixel
    reg_write(REG_WIDTH, 3);
    reg_write(REG_HEIGHT, 3);
    add_req(ACT_FLUSH, 24'h000000);
    add_req(ACT_PIXEL, 24'h000000);
    add_req(ACT_PIXEL, 24'hffffff);
    add_req(ACT_PIXEL, 24'h000001);
    add_req(ACT_PIXEL, 24'h555555);
    add_req(ACT_PIXEL, 24'haaaaaa);
    add_req(ACT_PIXEL, 24'h000000);
    add_req(ACT_FLUSH, 24'hffffff);
    add_req(ACT_PIXEL, 24'h010000);
    add_req(ACT_PIXEL, 24'h000100);
    add_req(ACT_PIXEL, 24'h000000);
    add_req(ACT_PIXEL, 24'h123456);
    for (int i = 0; i < 6; i++) add_req(ACT_FLUSH, 24'h000000);
    // zero scale saturates the straight weights, full scale drives weights of all but near-equal colors to zero
    reg_write(REG_SCALE, 0);
    queue_frame(2, 2);
    reg_write(REG_SCALE, 24'hffffff);
    queue_frame(2, 2);
    reg_write(REG_SCALE, 32'(SCALE_RESET));
    // partial frame, then a restart by width write; zero dims act as one
    for (int i = 0; i < 5; i++) add_req(ACT_PIXEL, 24'($urandom()));
    reg_write(REG_WIDTH, 0);
    reg_write(REG_HEIGHT, 0);
    queue_frame(1, 1);
    // oversize width acts as the widest row: first centers of a two row frame
    reg_write(REG_WIDTH, 2047);
    reg_write(REG_HEIGHT, 2);
    for (int i = 0; i < MAX_WIDTH + 4; i++) add_req(ACT_PIXEL, near_color(24'h808080));
    // narrow tall column
    reg_write(REG_WIDTH, 1);
    reg_write(REG_HEIGHT, 40);
    queue_frame(1, 40);

    // random frames through each idling pattern
    for (int ph = 0; ph < 4; ph++) begin
      int w, h;
      wait_drained();
      idle_phase = ph;
      phase_count = 0;
      while (phase_count < 180) begin
        w = ($urandom_range(9) == 0) ? $urandom_range(40, 64) : $urandom_range(1, 12);
        h = $urandom_range(1, 6);
        reg_write(REG_WIDTH, w);
        reg_write(REG_HEIGHT, h);
        if ($urandom_range(2) == 0) reg_write(REG_SCALE, $urandom_range(200000, 6000000));
        queue_frame(w, h);
        phase_count += w * h + w + 2;
        if (ph == 0 && hold_req == 0) hold_req++;
      end
    end

    wait_drained();
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
